### design/assert_macros.svh
// Assertion macros used by the port checker of this project.
// Needs only the clock and the active-low reset named at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, switched off during reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);

`endif

### design/lic_pkg.sv
// Shared types, constants and the status update function of the
// latching interrupt controller. Used by lic_core and the top level.
package lic_pkg;

	// operation codes of an input transaction
	typedef enum logic [2:0] {
		OP_SET   = 3'd0,
		OP_CLEAR = 3'd1,
		OP_PULSE = 3'd2,
		OP_READ  = 3'd3,
		OP_WRITE = 3'd4
	} lic_op_t;

	// register codes inside one bank (index bits 2..0)
	localparam logic [2:0] REG_STATUS = 3'd0;
	localparam logic [2:0] REG_ENABLE = 3'd1;
	localparam logic [2:0] REG_ACK    = 3'd2;
	localparam logic [2:0] REG_LATCH  = 3'd3;
	localparam logic [2:0] REG_INVERT = 3'd4;
	localparam logic [2:0] REG_MASKED = 3'd5;

	// global register indexes
	localparam logic [5:0] IDX_REVISION = 6'd20;
	localparam logic [5:0] IDX_COUNT    = 6'd21;

	localparam logic [31:0] REVISION_WORD = 32'h0001_0900;
	localparam logic [7:0]  COUNT_BYTE    = 8'd22;

	localparam int NUM_BANKS = 2;
	localparam int IN_BYTES  = 3;
	localparam int OUT_BYTES = 9;

	// one input transaction
	typedef struct packed {
		logic [7:0] wdata;
		logic [7:0] addr;
		logic [4:0] line;
		logic [2:0] op;
	} lic_item_t;

	// one result transaction
	typedef struct packed {
		logic [31:0] pending_second;
		logic [31:0] pending_first;
		logic [7:0]  rdata;
	} lic_result_t;

	// latched bits stick once set, unlatched bits follow the level
	function automatic logic [31:0] recompute_status(
		input logic [31:0] status,
		input logic [31:0] lvl,
		input logic [31:0] lat
	);
		return (lvl & ~lat) | ((status | lvl) & lat);
	endfunction

endpackage

### design/lic_core.sv
// State registers and single-pass update logic of the interrupt controller.
// Depends on lic_pkg for the item and result types and register codes.
module lic_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  lic_pkg::lic_item_t  item,
	output lic_pkg::lic_result_t result
);

	logic [31:0] level_q;
	logic [31:0] status_q [lic_pkg::NUM_BANKS];
	logic [31:0] enable_q [lic_pkg::NUM_BANKS];
	logic [31:0] latch_q  [lic_pkg::NUM_BANKS];
	logic [31:0] invert_q [lic_pkg::NUM_BANKS];

	logic [31:0] level_d;
	logic [31:0] status_d [lic_pkg::NUM_BANKS];
	logic [31:0] enable_d [lic_pkg::NUM_BANKS];
	logic [31:0] latch_d  [lic_pkg::NUM_BANKS];
	logic [31:0] invert_d [lic_pkg::NUM_BANKS];

	lic_pkg::lic_op_t op;
	logic [31:0] line_bit;
	logic [31:0] level_set;
	logic [31:0] level_clr;
	logic [31:0] first_level;
	logic [31:0] first_status [lic_pkg::NUM_BANKS];
	logic [5:0]  idx;
	logic        bank;
	logic [4:0]  shift;
	logic [31:0] lane_mask;
	logic [31:0] wbyte;
	logic [31:0] rword;
	logic [7:0]  rdata;

	assign op        = lic_pkg::lic_op_t'(item.op);
	assign line_bit  = 32'd1 << item.line;
	assign level_set = level_q | line_bit;
	assign level_clr = level_q & ~line_bit;
	// a clear drops the line at once; set and pulse raise it first
	assign first_level = (op == lic_pkg::OP_CLEAR) ? level_clr : level_set;

	assign idx       = item.addr[7:2];
	assign bank      = item.addr[5];
	assign shift     = {item.addr[1:0], 3'b000};
	assign lane_mask = 32'h0000_00FF << shift;
	assign wbyte     = {24'd0, item.wdata} << shift;

	// recompute status for the raised (or cleared) level of each bank
	always_comb begin
		for (int b = 0; b < lic_pkg::NUM_BANKS; b++) begin
			first_status[b] = lic_pkg::recompute_status(status_q[b],
				first_level ^ invert_q[b], latch_q[b]);
		end
	end

	// select the read word
	always_comb begin
		rword = 32'd0;
		if (idx[5:4] == 2'b00) begin
			case (idx[2:0])
				lic_pkg::REG_STATUS: rword = status_q[bank];
				lic_pkg::REG_ENABLE: rword = enable_q[bank];
				lic_pkg::REG_LATCH:  rword = latch_q[bank];
				lic_pkg::REG_INVERT: rword = invert_q[bank];
				lic_pkg::REG_MASKED: rword = status_q[bank] & enable_q[bank];
				default:             rword = 32'd0;
			endcase
		end else if (idx == lic_pkg::IDX_REVISION) begin
			rword = lic_pkg::REVISION_WORD;
		end else if (idx == lic_pkg::IDX_COUNT) begin
			// lanes 0 and 1 read the count, lanes 2 and 3 read zero
			rword = {16'd0, lic_pkg::COUNT_BYTE, lic_pkg::COUNT_BYTE};
		end
	end

	// next state and read byte for the current transaction
	always_comb begin
		level_d  = level_q;
		status_d = status_q;
		enable_d = enable_q;
		latch_d  = latch_q;
		invert_d = invert_q;
		rdata    = 8'd0;
		case (op)
			lic_pkg::OP_SET, lic_pkg::OP_CLEAR: begin
				level_d  = first_level;
				status_d = first_status;
			end
			lic_pkg::OP_PULSE: begin
				level_d = level_clr;
				for (int b = 0; b < lic_pkg::NUM_BANKS; b++) begin
					status_d[b] = lic_pkg::recompute_status(first_status[b],
						level_clr ^ invert_q[b], latch_q[b]);
				end
			end
			lic_pkg::OP_READ: begin
				rdata = 8'(rword >> shift);
			end
			lic_pkg::OP_WRITE: begin
				if (idx[5:4] == 2'b00) begin
					case (idx[2:0])
						lic_pkg::REG_ENABLE:
							enable_d[bank] = (enable_q[bank] & ~lane_mask) | wbyte;
						lic_pkg::REG_ACK:
							status_d[bank] = status_q[bank] & ~(wbyte & latch_q[bank]);
						lic_pkg::REG_LATCH:
							latch_d[bank] = (latch_q[bank] & ~lane_mask) | wbyte;
						lic_pkg::REG_INVERT:
							invert_d[bank] = (invert_q[bank] & ~lane_mask) | wbyte;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// commit state on each stepped transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			for (int b = 0; b < lic_pkg::NUM_BANKS; b++) begin
				status_q[b] <= '0;
				enable_q[b] <= '0;
				latch_q[b]  <= '0;
				invert_q[b] <= '0;
			end
		end else if (step) begin
			level_q  <= level_d;
			status_q <= status_d;
			enable_q <= enable_d;
			latch_q  <= latch_d;
			invert_q <= invert_d;
		end
	end

	assign result.rdata          = rdata;
	assign result.pending_first  = status_d[0] & enable_d[0];
	assign result.pending_second = status_d[1] & enable_d[1];

endmodule

### design/latching_interrupt_controller.sv
// Channel  Dir  Bits  Contents
// s_*      in   24    op, line, addr, wdata
// m_*      out  72    rdata, pending_first, pending_second
//
// One transaction per cycle sustained while m_tready stays high; each passes the
// input register, then the result register. State update is one shallow pass over 32-bit words.
// arst_n clears the line level and all bank registers to zero.
// A stalled result holds in the result register; one more transaction waits
// in the input register, then s_tready drops until m_tready returns.
// Top level of the latching interrupt controller; depends on lic_pkg, lic_core.
module latching_interrupt_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // op[2:0], line[7:3], addr[15:8], wdata[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // rdata[7:0], pending_first[39:8], pending_second[71:40]
);

	lic_pkg::lic_item_t   item_s1;
	logic                 valid_s1;
	lic_pkg::lic_result_t result;
	lic_pkg::lic_result_t result_s2;
	logic                 valid_s2;
	logic                 advance;

	// move the held transaction on when the result register is free
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= lic_pkg::lic_item_t'(s_tdata);
		end
	end

	lic_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

endmodule

### design/lic_port_checker.sv
// Port-level checks for the latching interrupt controller, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lic_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	logic s_txn;
	logic m_stall;

	assign s_txn   = s_tvalid && s_tready;
	assign m_stall = m_tvalid && !m_tready;

	// a stalled result keeps its data
	`ASSERT_NEXT(a_hold_stall, clk, arst_n, m_stall, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// the input side never blocks while the output side drains
	`ASSERT_IMPLIES(a_ready_follows, clk, arst_n, m_tready, s_tready, "s_tready low with m_tready high")

	// back-pressure only comes from a stalled result
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !s_tready, m_stall, "s_tready low without a stalled result")

	// a new result follows its input transaction through the input register and the result register
	`ASSERT_IMPLIES(a_latency, clk, arst_n, $rose(m_tvalid), $past(s_txn, 2), "result without input transaction")

endmodule

bind latching_interrupt_controller lic_port_checker u_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
